/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for clocked checks with async reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/core/tdp_pkg.sv */
// ----------------------------------------------------------------------------
// tdp_pkg
// Widths, wheel constants and shared types of the trial division prime test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

    // Candidate width and derived widths
    localparam int WIDTH = 32;
    localparam int DIV_W = WIDTH / 2 + 1;       // trial divisor, covers sqrt bound + wheel step
    localparam int SQ_W  = WIDTH + 2;           // running square of the trial divisor
    localparam int CNT_W = $clog2(WIDTH + 1);   // bit counter of the serial divider

    // Wheel constants (6k +/- 1)
    localparam int FIRST_ODD   = 3;
    localparam int WHEEL_FIRST = 5;
    localparam int WHEEL_STEP  = 6;
    localparam int WHEEL_GAP   = 2;

    // Status of the serial remainder unit
    typedef struct packed {
        logic done;      // remainder ready, one-cycle pulse
        logic is_zero;   // remainder is zero, valid with done
    } rem_stat_t;

endpackage

/* rtl/core/tdp_rem_serial.sv */
// ----------------------------------------------------------------------------
// tdp_rem_serial
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_rem_serial (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     launch,
    input  logic [tdp_pkg::WIDTH-1:0] dividend,
    input  logic [tdp_pkg::DIV_W-1:0] divisor,
    output tdp_pkg::rem_stat_t       stat
);
    import tdp_pkg::*;

    logic [WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // Shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, shift_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};

    // Advance one bit per cycle, restore on borrow
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (launch)
        begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = CNT_W'(WIDTH);
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            shift_next = {shift_reg[WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign stat.done    = done_reg;
    assign stat.is_zero = (rem_reg == '0);

endmodule

/* rtl/core/trial_division_prime_test.sv */
// Candidates 0..3 and even candidates finish without a trial division; otherwise the block runs trial
// divisions (mod 3, then i and i+2 per wheel step while i*i <= n) with one bound check
// per wheel step; a 32-bit prime takes about 10900 wheel steps.
// One candidate at a time: the bit-serial remainder unit sets the pace; start is taken
// in the cycle that done pulses. done is a one-cycle strobe, the receiver cannot stall.
// rst_n clears control state asynchronously; the block comes out idle.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division over the 6k +/- 1 wheel.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tdp_pkg::WIDTH-1:0] candidate,
    output logic                      busy,
    output logic                      done,
    output logic [tdp_pkg::WIDTH-1:0] tested_value,
    output logic                      prime_flag
);
    import tdp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOD3   = 3'd1;
    localparam logic [2:0] S_BOUND  = 3'd2;
    localparam logic [2:0] S_DIV_LO = 3'd3;
    localparam logic [2:0] S_DIV_HI = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic             done_reg, done_next;
    logic             flag_reg, flag_next;
    logic             launch;
    logic [DIV_W-1:0] rem_divisor;
    rem_stat_t        rem_stat;
    logic [SQ_W-1:0]  sq_step;

    // Serial remainder unit
    tdp_rem_serial u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (launch),
        .dividend (n_next),
        .divisor  (rem_divisor),
        .stat     (rem_stat)
    );

    // (i+6)^2 - i^2 = 12*i + 36
    assign sq_step = (SQ_W'(d_reg) << 3) + (SQ_W'(d_reg) << 2)
                   + SQ_W'(WHEEL_STEP * WHEEL_STEP);

    // Sequence the trial divisions
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        done_next   = 1'b0;
        flag_next   = flag_reg;
        launch      = 1'b0;
        rem_divisor = d_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = candidate;
                    if (candidate <= WIDTH'(FIRST_ODD))
                    begin
                        done_next = 1'b1;
                        flag_next = candidate[1];
                    end
                    else if (!candidate[0])
                    begin
                        done_next = 1'b1;
                        flag_next = 1'b0;
                    end
                    else
                    begin
                        launch      = 1'b1;
                        rem_divisor = DIV_W'(FIRST_ODD);
                        state_next  = S_MOD3;
                    end
                end
            end
            S_MOD3:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.is_zero)
                    begin
                        done_next  = 1'b1;
                        flag_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = DIV_W'(WHEEL_FIRST);
                        sq_next    = SQ_W'(WHEEL_FIRST * WHEEL_FIRST);
                        state_next = S_BOUND;
                    end
                end
            end
            S_BOUND:
            begin
                if (sq_reg > SQ_W'(n_reg))
                begin
                    done_next  = 1'b1;
                    flag_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    launch     = 1'b1;
                    state_next = S_DIV_LO;
                end
            end
            S_DIV_LO:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.is_zero)
                    begin
                        done_next  = 1'b1;
                        flag_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        launch      = 1'b1;
                        rem_divisor = d_reg + DIV_W'(WHEEL_GAP);
                        state_next  = S_DIV_HI;
                    end
                end
            end
            S_DIV_HI:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.is_zero)
                    begin
                        done_next  = 1'b1;
                        flag_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + DIV_W'(WHEEL_STEP);
                        sq_next    = sq_reg + sq_step;
                        state_next = S_BOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            flag_reg  <= flag_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        d_reg  <= d_next;
        sq_reg <= sq_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign tested_value = n_reg;
    assign prime_flag   = flag_reg;

endmodule

/* rtl/core/tdp_checker.sv */
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks of the prime test command interface, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdp_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tdp_pkg::WIDTH-1:0] candidate,
    input  logic                      busy,
    input  logic                      done,
    input  logic [tdp_pkg::WIDTH-1:0] tested_value,
    input  logic                      prime_flag
);
    import tdp_pkg::*;

    logic accept;
    logic trivial;
    logic trivial_flag;

    assign accept       = start && !busy;
    assign trivial      = (candidate <= WIDTH'(FIRST_ODD)) || !candidate[0];
    assign trivial_flag = candidate[1] && (candidate <= WIDTH'(FIRST_ODD));

    // An accepted command either runs or completes at once
    `ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || done)
    // A result transfer ends the run
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    // A result transfer follows a run or a fresh command
    `ASSERT_IMPLY(a_done_cause, clk, rst_n, done, $past(busy) || $past(start))
    // Trivial candidates finish at once with the echoed value and known flag
    `ASSERT_NEXT(a_trivial_result, clk, rst_n, accept && trivial, done && (tested_value == $past(candidate)) && (prime_flag == $past(trivial_flag)))

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .candidate    (candidate),
    .busy         (busy),
    .done         (done),
    .tested_value (tested_value),
    .prime_flag   (prime_flag)
);
